FILE: rtl/mcbps_pkg.sv
// ----------------------------------------------------------------------------
// Blink pattern sequencer package
// Shared widths, request codes and the per-channel control and status types.
// ----------------------------------------------------------------------------
package mcbps_pkg;

  // Configuration of the sequencer.
  localparam int unsigned CHANNELS    = 5;
  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned COUNT_WIDTH = 16;

  // Field widths of the request and result items.
  localparam int unsigned REQ_W    = 1;
  localparam int unsigned CH_W     = 3;
  localparam int unsigned CNT_IN_W = 16;
  localparam int unsigned PAT_W    = 32;
  localparam int unsigned LEN_IN_W = 6;
  localparam int unsigned OUT_W    = 5;

  // Stored length and step position must hold values up to PATTERN_MAX.
  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  // Request type codes.
  localparam logic [REQ_W-1:0] REQ_TICK = 1'b0;
  localparam logic [REQ_W-1:0] REQ_LOAD = 1'b1;

  // Per-channel strobes from the top level.
  typedef struct packed {
    logic tick;
    logic load;
  } mcbps_ctrl_t;

  // Per-channel state after the current request.
  typedef struct packed {
    logic lamp;
    logic active;
  } mcbps_stat_t;

endpackage

FILE: rtl/mcbps_channel.sv
// ----------------------------------------------------------------------------
// Blink pattern channel
// Holds one channel's pattern, length, step position, repeat count and lamp,
// and updates them on a tick or load strobe.
// ----------------------------------------------------------------------------
module mcbps_channel (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcbps_pkg::mcbps_ctrl_t            ctrl_i,
  input  logic [mcbps_pkg::PAT_W-1:0]       pattern_i,
  input  logic [mcbps_pkg::LEN_W-1:0]       length_i,
  input  logic [mcbps_pkg::COUNT_WIDTH-1:0] count_i,
  output mcbps_pkg::mcbps_stat_t            stat_o
);
  import mcbps_pkg::*;

  logic [PAT_W-1:0]       pattern_q, pattern_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [LEN_W-1:0]       pos_q, pos_d;
  logic [COUNT_WIDTH-1:0] rep_q, rep_d;
  logic                   lamp_q, lamp_d;
  logic [PAT_W-1:0]       pattern_shift;

  // Steps beyond the stored pattern width shift out to zero and read as off.
  assign pattern_shift = pattern_q >> pos_q;

  // Next state for a load or a tick.
  always_comb begin
    pattern_d = pattern_q;
    len_d     = len_q;
    pos_d     = pos_q;
    rep_d     = rep_q;
    lamp_d    = lamp_q;
    if (ctrl_i.load) begin
      pattern_d = pattern_i;
      len_d     = length_i;
      rep_d     = count_i;
      pos_d     = '0;
    end else if (ctrl_i.tick && (rep_q != '0)) begin
      if (pos_q >= len_q) begin
        // End of the pattern: lamp off, rewind and count one repetition.
        pos_d  = '0;
        rep_d  = rep_q - 1'b1;
        lamp_d = 1'b0;
      end else begin
        lamp_d = pattern_shift[0];
        pos_d  = pos_q + 1'b1;
      end
    end
  end

  // Channel state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= '0;
      pos_q     <= '0;
      rep_q     <= '0;
      lamp_q    <= 1'b0;
    end else begin
      pattern_q <= pattern_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      rep_q     <= rep_d;
      lamp_q    <= lamp_d;
    end
  end

  assign stat_o.lamp   = lamp_d;
  assign stat_o.active = (rep_d != '0);

endmodule

FILE: rtl/multi_channel_blink_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// Multi-channel blink pattern sequencer
// Plays stored on/off patterns on five lamp outputs, advanced by tick requests.
// ----------------------------------------------------------------------------
// A request is held in the request register and its result in the result
// register. Throughput: one request per cycle unless the output stalls; the two
// registers let a new request enter while a finished result waits to be taken.
// Reset: asynchronous, active low; clears all patterns, lengths, positions,
// repeat counts and lamps, and empties both registers.
module multi_channel_blink_pattern_sequencer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mcbps_pkg::REQ_W-1:0]    req_type_i,
  input  logic [mcbps_pkg::CH_W-1:0]     channel_i,
  input  logic [mcbps_pkg::CNT_IN_W-1:0] repeat_count_i,
  input  logic [mcbps_pkg::PAT_W-1:0]    pattern_bits_i,
  input  logic [mcbps_pkg::LEN_IN_W-1:0] pattern_length_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mcbps_pkg::OUT_W-1:0]    lamp_states_o,
  output logic [mcbps_pkg::OUT_W-1:0]    active_mask_o
);
  import mcbps_pkg::*;

  logic                in_valid_q;
  logic [REQ_W-1:0]    req_q;
  logic [CH_W-1:0]     channel_q;
  logic [CNT_IN_W-1:0] count_q;
  logic [PAT_W-1:0]    pattern_q;
  logic [LEN_IN_W-1:0] length_q;

  logic                out_valid_q;
  logic [OUT_W-1:0]    lamp_q;
  logic [OUT_W-1:0]    active_q;

  logic                out_ready;
  logic                advance;
  logic                in_accept;
  logic [LEN_W-1:0]    len_sat;
  logic [CHANNELS-1:0] lamp_vec;
  logic [CHANNELS-1:0] active_vec;

  // Handshake: the request register moves on whenever the result register
  // is empty or its result is being taken.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q     <= req_type_i;
      channel_q <= channel_i;
      count_q   <= repeat_count_i;
      pattern_q <= pattern_bits_i;
      length_q  <= pattern_length_i;
    end
  end

  // Lengths above the pattern capacity saturate.
  assign len_sat = (int'(length_q) > int'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                        : LEN_W'(length_q);

  // One channel instance per output; loads to channels out of range match none.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    mcbps_ctrl_t ctrl;
    mcbps_stat_t stat;

    assign ctrl.tick = advance && (req_q == REQ_TICK);
    assign ctrl.load = advance && (req_q == REQ_LOAD) && (int'(channel_q) == i);

    mcbps_channel u_channel (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .pattern_i (pattern_q),
      .length_i  (len_sat),
      .count_i   (COUNT_WIDTH'(count_q)),
      .stat_o    (stat)
    );

    assign lamp_vec[i]   = stat.lamp;
    assign active_vec[i] = stat.active;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lamp_q   <= OUT_W'(lamp_vec);
      active_q <= OUT_W'(active_vec);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lamp_states_o = lamp_q;
  assign active_mask_o = active_q;

endmodule

FILE: rtl/mcbps_checker.sv
// ----------------------------------------------------------------------------
// Blink pattern sequencer checker
// Port-level assertions on the sequencer top level, attached by bind.
// ----------------------------------------------------------------------------
module mcbps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [mcbps_pkg::OUT_W-1:0] lamp_states_o,
  input logic [mcbps_pkg::OUT_W-1:0] active_mask_o
);

  // Once reset has been seen low at an edge, no result is shown after it.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(lamp_states_o) && $stable(active_mask_o))
    else $error("stalled result changed");

  // Requests back up only behind a result that is itself stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the output free");

  // Between consecutive results, at most one channel becomes active (one load).
  a_one_new_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) ##1 out_valid_o |->
      $countones(active_mask_o & ~$past(active_mask_o)) <= 1)
    else $error("more than one channel started by one request");

  // A lamp only switches on while its channel is playing.
  a_lamp_on_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) ##1 out_valid_o |->
      (lamp_states_o & ~$past(lamp_states_o) & ~active_mask_o) == '0)
    else $error("lamp switched on for an idle channel");

endmodule

bind multi_channel_blink_pattern_sequencer_core mcbps_checker u_mcbps_checker (.*);

FILE: tb/sv/tb_multi_channel_blink_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// Blink pattern sequencer testbench
// Drives tick and load requests into the sequencer and checks each returned
// lamp and active mask against a cycle-free model of the five channels. A
// short directed opening covers the field extremes and corner cases; random
// load-and-tick sequences with random idling on both sides follow.
// ----------------------------------------------------------------------------
module tb_multi_channel_blink_pattern_sequencer_core;
  import mcbps_pkg::*;

  localparam int unsigned RANDOM_REQS = 1400;
  localparam int unsigned QUIET_TAIL  = 120;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One request as it is driven onto the input ports.
  typedef struct packed {
    logic [REQ_W-1:0]    kind;
    logic [CH_W-1:0]     chan;
    logic [CNT_IN_W-1:0] reps;
    logic [PAT_W-1:0]    bits;
    logic [LEN_IN_W-1:0] len;
  } blink_req_t;

  // One expected result.
  typedef struct packed {
    logic [OUT_W-1:0] lamps;
    logic [OUT_W-1:0] active;
  } lamp_view_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    req_type      = REQ_TICK;
  logic [CH_W-1:0]     channel       = '0;
  logic [CNT_IN_W-1:0] repeat_count  = '0;
  logic [PAT_W-1:0]    pattern_bits  = '0;
  logic [LEN_IN_W-1:0] pattern_len   = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [OUT_W-1:0]    lamp_states;
  logic [OUT_W-1:0]    active_mask;

  blink_req_t pending_reqs[$];
  lamp_view_t lamp_expect[$];

  // Model state of the channels.
  logic [PAT_W-1:0]       pat_mem [CHANNELS];
  logic [LEN_W-1:0]       len_mem [CHANNELS];
  logic [LEN_W-1:0]       pos_mem [CHANNELS];
  logic [COUNT_WIDTH-1:0] rep_mem [CHANNELS];
  logic [CHANNELS-1:0]    lamp_reg;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned taken_count    = 0;
  int unsigned idle_pct       = 8;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  logic        req_taken      = 1'b0;

  multi_channel_blink_pattern_sequencer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .channel_i        (channel),
    .repeat_count_i   (repeat_count),
    .pattern_bits_i   (pattern_bits),
    .pattern_length_i (pattern_len),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .lamp_states_o    (lamp_states),
    .active_mask_o    (active_mask)
  );

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Applies one request to the channel model and queues the resulting view.
  task automatic advance_lamp_model(input blink_req_t r);
    lamp_view_t       view;
    logic [LEN_W-1:0] len_sat;
    int               c;
    if (r.kind == REQ_TICK) begin
      for (c = 0; c < CHANNELS; c++) begin
        if (rep_mem[c] != '0) begin
          // End of the pattern: lamp off, rewind, one repetition used up.
          if (pos_mem[c] >= len_mem[c]) begin
            pos_mem[c]  = '0;
            rep_mem[c]  = rep_mem[c] - 1'b1;
            lamp_reg[c] = 1'b0;
          end else begin
            lamp_reg[c] = pat_mem[c][pos_mem[c]];
            pos_mem[c]  = pos_mem[c] + 1'b1;
          end
        end
      end
    end else if (r.chan < CHANNELS) begin
      // A load leaves the lamp alone; lengths above the maximum saturate.
      len_sat = (r.len > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : LEN_W'(r.len);
      pat_mem[r.chan] = r.bits;
      len_mem[r.chan] = len_sat;
      rep_mem[r.chan] = r.reps;
      pos_mem[r.chan] = '0;
    end
    view.lamps  = lamp_reg;
    view.active = '0;
    for (c = 0; c < CHANNELS; c++) begin
      view.active[c] = (rep_mem[c] != '0);
    end
    lamp_expect.push_back(view);
  endtask

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [CH_W-1:0] chan,
                           input logic [CNT_IN_W-1:0] reps, input logic [PAT_W-1:0] bits,
                           input logic [LEN_IN_W-1:0] len);
    blink_req_t r;
    r.kind = kind;
    r.chan = chan;
    r.reps = reps;
    r.bits = bits;
    r.len  = len;
    pending_reqs.push_back(r);
  endtask

  // A tick with junk in the fields it ignores.
  task automatic queue_tick();
    queue_req(REQ_TICK, CH_W'($urandom_range(0, 7)), CNT_IN_W'($urandom),
              $urandom, LEN_IN_W'($urandom));
  endtask

  // A load with random content weighted toward short patterns and few repeats.
  task automatic queue_random_load();
    logic [CH_W-1:0]     chan;
    logic [CNT_IN_W-1:0] reps;
    logic [PAT_W-1:0]    bits;
    logic [LEN_IN_W-1:0] len;
    int unsigned         pick;
    chan = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(5, 7))
                                       : CH_W'($urandom_range(0, CHANNELS - 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) reps = '0;
    else if (pick == 1) reps = CNT_IN_W'($urandom);
    else if (pick == 2) reps = '1;
    else reps = CNT_IN_W'($urandom_range(1, 3));
    pick = $urandom_range(0, 9);
    if (pick == 0) bits = '0;
    else if (pick == 1) bits = '1;
    else bits = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = LEN_IN_W'($urandom_range(0, 6));
    else if (pick < 9) len = LEN_IN_W'($urandom_range(7, 32));
    else len = LEN_IN_W'($urandom_range(33, 63));
    queue_req(REQ_LOAD, chan, reps, bits, len);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_multi_channel_blink_pattern_sequencer_core failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned n;
    for (n = 0; n < CHANNELS; n++) begin
      pat_mem[n] = '0;
      len_mem[n] = '0;
      pos_mem[n] = '0;
      rep_mem[n] = '0;
    end
    lamp_reg = '0;

    // Directed opening: idle tick, full and saturated lengths, zero length,
    // channels out of range, a zero count, and a zero-count load on a lit lamp.
    queue_req(REQ_TICK, 3'd7, '1, '1, '1);
    queue_req(REQ_LOAD, 3'd0, 16'd1, 32'hFFFF_FFFF, 6'd32);
    queue_req(REQ_LOAD, 3'd4, 16'hFFFF, 32'hAAAA_AAAA, 6'd63);
    queue_req(REQ_LOAD, 3'd1, 16'd2, 32'h0000_0000, 6'd0);
    queue_req(REQ_LOAD, 3'd5, 16'd3, 32'hFFFF_FFFF, 6'd4);
    queue_req(REQ_LOAD, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
    queue_req(REQ_LOAD, 3'd2, 16'd0, 32'hFFFF_FFFF, 6'd5);
    queue_req(REQ_LOAD, 3'd3, 16'd2, 32'h0000_0001, 6'd1);
    repeat (4) queue_tick();
    queue_req(REQ_LOAD, 3'd0, 16'd0, 32'hFFFF_FFFF, 6'd32);
    queue_tick();
    queue_req(REQ_LOAD, 3'd3, 16'd1, 32'h8000_0000, 6'd32);
    queue_req(REQ_LOAD, 3'd1, 16'hFFFF, 32'h5555_5555, 6'd33);
    repeat (5) queue_tick();
    queue_req(REQ_LOAD, 3'd6, 16'd0, 32'h0000_0000, 6'd0);
    repeat (2) queue_tick();

    // Random part: short load bursts followed by runs of ticks.
    n = 0;
    while (n < RANDOM_REQS) begin
      repeat ($urandom_range(1, 3)) begin
        queue_random_load();
        n++;
      end
      repeat ($urandom_range(1, 40)) begin
        queue_tick();
        n++;
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || lamp_expect.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_multi_channel_blink_pattern_sequencer_core passed");
    end else begin
      $display("tb_multi_channel_blink_pattern_sequencer_core failed");
    end
    $finish;
  end

  // Driver: request side and result stall, changed on the falling edge.
  always @(negedge clk_i) begin
    int unsigned pct;
    blink_req_t  r;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      pct = (pending_reqs.size() < QUIET_TAIL) ? 0 : idle_pct;
      // Result stall comes in bursts.
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (pct != 0 && $urandom_range(1, 100) <= pct) begin
        stall_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      // A request is held until it is taken; gaps fall only between requests.
      if (!in_valid || req_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && pct != 0 && $urandom_range(1, 100) <= pct) begin
          gap_left = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          r = pending_reqs[0];
          req_type     <= r.kind;
          channel      <= r.chan;
          repeat_count <= r.reps;
          pattern_bits <= r.bits;
          pattern_len  <= r.len;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and feeds accepted requests to the model.
  always @(posedge clk_i) begin
    lamp_view_t want;
    blink_req_t r;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (lamp_expect.size() == 0) begin
          report_mismatch($sformatf("result lamps=%h active=%h with no request pending",
                                    lamp_states, active_mask));
        end else begin
          want = lamp_expect.pop_front();
          if (lamp_states !== want.lamps) begin
            report_mismatch($sformatf("lamp_states got %h, want %h", lamp_states, want.lamps));
          end
          if (active_mask !== want.active) begin
            report_mismatch($sformatf("active_mask got %h, want %h", active_mask, want.active));
          end
        end
      end
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        r.kind = req_type;
        r.chan = channel;
        r.reps = repeat_count;
        r.bits = pattern_bits;
        r.len  = pattern_len;
        advance_lamp_model(r);
        void'(pending_reqs.pop_front());
        taken_count++;
        // Change the idling density now and then, sometimes to none at all.
        if (taken_count % 64 == 0) begin
          idle_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 15);
        end
      end
    end
  end

endmodule
